// File: hdl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants for the matrix multiply-accumulate block
// Field widths, action codes, register indexes and the queue command record.
// ----------------------------------------------------------------------------
package mma_pkg;

   localparam int DEFAULT_MAX_DIM = 8;

   localparam int ACT_W     = 2;
   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int ELEM_W    = 16;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int ACC_W     = 48;
   localparam int CSR_IDX_W = 2;

   localparam int QUEUE_DEPTH = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INNER = 2'd2;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD_A  = 2'd0,
      ACT_LOAD_B  = 2'd1,
      ACT_LOAD_C  = 2'd2,
      ACT_COMPUTE = 2'd3
   } action_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
      logic [DIM_W-1:0] inner;
   } dims_type;

   typedef struct packed {
      action_type               act;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [ELEM_W-1:0] elem;
      logic signed [ACC_W-1:0]  acc;
   } cmd_type;

endpackage

// File: hdl/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mma_fifo.sv
// ----------------------------------------------------------------------------
// mma_fifo: command queue between front and back
// Short register FIFO of decoded commands.
// ----------------------------------------------------------------------------
module mma_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mma_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output mma_pkg::cmd_type head
);
   import mma_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = q_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hdl/mma_front.sv
// ----------------------------------------------------------------------------
// mma_front: accept side of the matrix multiply-accumulate block
// Holds the dimension registers, range-checks loads and queues commands.
// ----------------------------------------------------------------------------
module mma_front #(
   parameter int MAX_DIM = mma_pkg::DEFAULT_MAX_DIM
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mma_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mma_pkg::DIM_W-1:0]             csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mma_pkg::ACT_W-1:0]             req_action,
   input  logic [mma_pkg::IDX_W-1:0]             req_row_index,
   input  logic [mma_pkg::IDX_W-1:0]             req_col_index,
   input  logic signed [mma_pkg::ELEM_W-1:0]     req_element_value,
   input  logic signed [mma_pkg::ACC_W-1:0]      req_acc_value,
   output mma_pkg::dims_type                     dims,
   output logic                                  push,
   output mma_pkg::cmd_type                      push_cmd,
   input  logic                                  q_full
);
   import mma_pkg::*;

   dims_type         dims_ff, dims_in;
   logic [DIM_W-1:0] wdata_clamped;
   logic [DIM_W-1:0] row_ext, col_ext;
   action_type       act;
   logic             keep;

   // zero reads as one, anything above the array size as the array size
   always_comb begin
      if (csr_wdata == '0) begin
         wdata_clamped = DIM_W'(1);
      end else if (csr_wdata > DIM_W'(MAX_DIM)) begin
         wdata_clamped = DIM_W'(MAX_DIM);
      end else begin
         wdata_clamped = csr_wdata;
      end
   end

   always_comb begin
      dims_in = dims_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ROWS:  dims_in.rows  = wdata_clamped;
            REG_COLS:  dims_in.cols  = wdata_clamped;
            REG_INNER: dims_in.inner = wdata_clamped;
            default:   dims_in = dims_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.rows  <= DIM_W'(MAX_DIM);
         dims_ff.cols  <= DIM_W'(MAX_DIM);
         dims_ff.inner <= DIM_W'(MAX_DIM);
      end else begin
         dims_ff <= dims_in;
      end
   end

   assign csr_ready = 1'b1;
   assign dims      = dims_ff;

   assign act     = action_type'(req_action);
   assign row_ext = {1'b0, req_row_index};
   assign col_ext = {1'b0, req_col_index};

   // out-of-range loads are swallowed here and never reach the queue
   always_comb begin
      unique case (act)
         ACT_LOAD_A:  keep = (row_ext < dims_ff.rows)  && (col_ext < dims_ff.inner);
         ACT_LOAD_B:  keep = (row_ext < dims_ff.inner) && (col_ext < dims_ff.cols);
         ACT_LOAD_C:  keep = (row_ext < dims_ff.rows)  && (col_ext < dims_ff.cols);
         ACT_COMPUTE: keep = 1'b1;
         default:     keep = 1'b0;
      endcase
   end

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full && keep;

   always_comb begin
      push_cmd.act  = act;
      push_cmd.row  = req_row_index;
      push_cmd.col  = req_col_index;
      push_cmd.elem = req_element_value;
      push_cmd.acc  = req_acc_value;
   end

endmodule

// File: hdl/mma_back.sv
// ----------------------------------------------------------------------------
// mma_back: execute side of the matrix multiply-accumulate block
// Writes loads into the stores and sequences the multiply-accumulate loop.
// ----------------------------------------------------------------------------
module mma_back #(
   parameter int MAX_DIM = mma_pkg::DEFAULT_MAX_DIM
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mma_pkg::dims_type                 dims,
   input  logic                              q_not_empty,
   input  mma_pkg::cmd_type                  q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mma_pkg::IDX_W-1:0]         rsp_out_row,
   output logic [mma_pkg::IDX_W-1:0]         rsp_out_col,
   output logic signed [mma_pkg::ACC_W-1:0]  rsp_out_value,
   output logic                              rsp_last
);
   import mma_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic signed [ACC_W:0] SUM_MAX = (ACC_W+1)'(49'sh0_7FFF_FFFF_FFFF);
   localparam logic signed [ACC_W:0] SUM_MIN = -SUM_MAX - (ACC_W+1)'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic rd_vld_ff, rd_vld_in, rd_first_ff, rd_first_in, rd_last_ff, rd_last_in;
   logic prd_vld_ff, prd_first_ff, prd_last_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic acc_done_ff, acc_done_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [IDX_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic signed [ACC_W-1:0] rsp_value_ff, rsp_value_in;

   logic out_free, emit, i_end, j_end, k_end, idle_load;
   logic a_we, b_we, c_we;
   logic [ADDR_W-1:0] ld_addr, a_rd_addr, b_rd_addr, c_addr, c_wr_addr;
   logic [ELEM_W-1:0] a_rdata, b_rdata;
   logic [ACC_W-1:0]  c_rdata, c_wdata;
   logic signed [ACC_W-1:0] acc_base;
   logic signed [ACC_W:0]   sum;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      addr_of = ADDR_W'(r) + ADDR_W'(c) * ADDR_W'(MAX_DIM);
   endfunction

   // ---------------- stores ----------------
   assign idle_load = (state_ff == S_IDLE) && q_not_empty;
   assign ld_addr   = addr_of(q_head.row, q_head.col);
   assign a_we      = idle_load && (q_head.act == ACT_LOAD_A);
   assign b_we      = idle_load && (q_head.act == ACT_LOAD_B);
   assign c_we      = (idle_load && (q_head.act == ACT_LOAD_C)) || emit;
   assign c_addr    = addr_of(i_ff, j_ff);
   assign c_wr_addr = emit ? c_addr : ld_addr;
   assign c_wdata   = emit ? acc_ff : q_head.acc;
   assign a_rd_addr = addr_of(i_ff, k_ff);
   assign b_rd_addr = addr_of(k_ff, j_ff);

   mma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (ld_addr),
      .wr_data (q_head.elem),
      .rd_addr (a_rd_addr),
      .rd_data (a_rdata)
   );

   mma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (ld_addr),
      .wr_data (q_head.elem),
      .rd_addr (b_rd_addr),
      .rd_data (b_rdata)
   );

   // c address stays on (i, j) for the whole element, so its read data is
   // ready by the time the first product reaches the accumulator
   mma_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_c_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_wr_addr),
      .wr_data (c_wdata),
      .rd_addr (c_addr),
      .rd_data (c_rdata)
   );

   // ---------------- datapath ----------------
   assign acc_base = prd_first_ff ? $signed(c_rdata) : acc_ff;
   assign sum      = {acc_base[ACC_W-1], acc_base} +
                     {{(ACC_W + 1 - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      acc_in = acc_ff;
      if (prd_vld_ff) begin
         if (sum > SUM_MAX) begin
            acc_in = SUM_MAX[ACC_W-1:0];
         end else if (sum < SUM_MIN) begin
            acc_in = SUM_MIN[ACC_W-1:0];
         end else begin
            acc_in = sum[ACC_W-1:0];
         end
      end
      acc_done_in = prd_vld_ff && prd_last_ff;
   end

   // ---------------- sequencer ----------------
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (state_ff == S_EMIT) && out_free;
   assign i_end    = ({1'b0, i_ff} + DIM_W'(1)) == dims.rows;
   assign j_end    = ({1'b0, j_ff} + DIM_W'(1)) == dims.cols;
   assign k_end    = ({1'b0, k_ff} + DIM_W'(1)) == dims.inner;
   assign q_pop    = idle_load;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rd_vld_in    = 1'b0;
      rd_first_in  = (k_ff == '0);
      rd_last_in   = k_end;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_not_empty && (q_head.act == ACT_COMPUTE)) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            rd_vld_in = 1'b1;
            if (k_end) begin
               state_in = S_WAIT;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         S_WAIT: begin
            if (acc_done_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = i_ff;
               rsp_col_in   = j_ff;
               rsp_value_in = acc_ff;
               rsp_last_in  = i_end && j_end;
               k_in         = '0;
               // column-major walk: row inner, column outer
               if (i_end) begin
                  i_in = '0;
                  if (j_end) begin
                     state_in = S_IDLE;
                  end else begin
                     j_in     = j_ff + IDX_W'(1);
                     state_in = S_ISSUE;
                  end
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = S_ISSUE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_vld_ff    <= 1'b0;
         prd_vld_ff   <= 1'b0;
         acc_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         prd_vld_ff   <= rd_vld_ff;
         acc_done_ff  <= acc_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      rd_first_ff  <= rd_first_in;
      rd_last_ff   <= rd_last_in;
      prd_first_ff <= rd_first_ff;
      prd_last_ff  <= rd_last_ff;
      prod_ff      <= $signed(a_rdata) * $signed(b_rdata);
      acc_ff       <= acc_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

   // ---------------- assertions ----------------
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      acc_done_ff |-> state_ff == S_WAIT)
      else $error("accumulation finished outside the wait state");

   a_pipe_empty_on_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> !rd_vld_ff && !prd_vld_ff)
      else $error("multiply pipeline busy while emitting");

   a_rd_follows_issue: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == S_ISSUE))
      else $error("store read without an issue cycle");

   a_last_is_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |->
         (({1'b0, rsp_row_ff} + DIM_W'(1)) == dims.rows) &&
         (({1'b0, rsp_col_ff} + DIM_W'(1)) == dims.cols))
      else $error("last flag on an element other than the final one");

endmodule

// File: hdl/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate: fixed-point C = C + A * B
// Load items fill the A, B and C stores; a compute item updates C in place
// and streams every C element out in column-major order.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write rows_in_use (0), cols_in_use (1), inner_in_use (2); only
//            while the block is idle. Always ready.
//   req_*  : one item per handshake. Loads go to a two-entry command queue
//            and retire one per cycle when idle; out-of-range ones drop at once.
//   rsp_*  : one item per C element, rsp_last on the final one.
// Throughput: loads sustain one per cycle while no compute is running. A
//   compute is bound by the single shared multiply-add: per element, one
//   issue per inner index, then the read/multiply/accumulate pipeline drains,
//   then C is written back and the output register loaded in the same cycle.
// The output is a single register; when rsp_ready is low the sequencer waits
// and the queue fills, then req_ready drops.
// Reset clears control state and sets all dimensions to MAX_DIM; store
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate #(
   parameter int MAX_DIM = mma_pkg::DEFAULT_MAX_DIM
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mma_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mma_pkg::DIM_W-1:0]         csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mma_pkg::ACT_W-1:0]         req_action,
   input  logic [mma_pkg::IDX_W-1:0]         req_row_index,
   input  logic [mma_pkg::IDX_W-1:0]         req_col_index,
   input  logic signed [mma_pkg::ELEM_W-1:0] req_element_value,
   input  logic signed [mma_pkg::ACC_W-1:0]  req_acc_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mma_pkg::IDX_W-1:0]         rsp_out_row,
   output logic [mma_pkg::IDX_W-1:0]         rsp_out_col,
   output logic signed [mma_pkg::ACC_W-1:0]  rsp_out_value,
   output logic                              rsp_last
);
   import mma_pkg::*;

   dims_type dims;
   logic     push, q_full, pop, q_not_empty;
   cmd_type  push_cmd, q_head;

   mma_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .req_acc_value     (req_acc_value),
      .dims              (dims),
      .push              (push),
      .push_cmd          (push_cmd),
      .q_full            (q_full)
   );

   mma_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   mma_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock         (clock),
      .reset         (reset),
      .dims          (dims),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .q_pop         (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule
